// ----- hw/rtl/fswm_pkg.sv -----
package fswm_pkg;

    localparam int unsigned MB_W   = 40;
    localparam int unsigned UTIL_W = 7;
    localparam int unsigned TICK_W = 8;
    // shared adder width: free_mb * 100 needs 47 bits
    localparam int unsigned UNIT_W = 48;

    // configuration register indexes
    localparam logic [2:0] REG_TOTAL_MB       = 3'd0;
    localparam logic [2:0] REG_MIN_FREE_MB    = 3'd1;
    localparam logic [2:0] REG_HWM_FREE_MB    = 3'd2;
    localparam logic [2:0] REG_REMINDER_TICKS = 3'd3;
    localparam logic [2:0] REG_SOLO_MODE      = 3'd4;

    // message codes
    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_ENTER  = 2'd1;
    localparam logic [1:0] MSG_REMIND = 2'd2;
    localparam logic [1:0] MSG_LEAVE  = 2'd3;

    localparam logic [UTIL_W-1:0] UTIL_FULL = 7'd100;

    typedef struct packed {
        logic [MB_W-1:0] free_mb;
        logic [MB_W-1:0] largest_free_mb;
    } t_in_word;

    typedef struct packed {
        logic [UTIL_W-1:0] util_percent;
        logic              no_space;
        logic              report_state;
        logic [1:0]        message_kind;
    } t_out_word;

    typedef struct packed {
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
        logic              sub;
    } t_unit_op;

    typedef struct packed {
        logic [UNIT_W-1:0] sum;
        logic              carry;
    } t_unit_res;

endpackage

// ----- hw/rtl/fswm_addsub.sv -----
module fswm_addsub (
    input  fswm_pkg::t_unit_op  i_op,
    output fswm_pkg::t_unit_res o_res
);
    import fswm_pkg::*;

    logic [UNIT_W:0] w_full;

    // a - b as a + ~b + 1; carry out set means a >= b
    assign w_full = {1'b0, i_op.a} + {1'b0, (i_op.sub ? ~i_op.b : i_op.b)}
                  + {{UNIT_W{1'b0}}, i_op.sub};

    assign o_res.sum   = w_full[UNIT_W-1:0];
    assign o_res.carry = w_full[UNIT_W];

endmodule

// ----- hw/rtl/free_space_watermark_monitor.sv -----
// Free-space watermark monitor. Each input word is one poll tick carrying
// total free space and the largest free extent in MB; each tick returns
// exactly one result word with utilization percent (100 - floor(free*100/total),
// clamped to 0..100, 100 when total_mb is 0), the no-space flag
// after the tick, a state-report strobe and a message code. The flag sets
// when the largest extent falls below min_free_mb and clears only once it
// reaches hwm_free_mb; while it stays set a reminder message repeats every
// reminder_ticks+1 ticks. Compares, multiply and divide all run through one
// 48-bit add/subtract unit under a small sequencer: threshold compare,
// free-vs-total compare, two shift-add passes forming free*100, then a
// 7-step restoring divide (the quotient is known to be below 100 once
// free < total). A word passes S_CMPL through S_DONE before the next is
// taken in S_IDLE; S_DONE waits while the output register is full and not
// read. The input is taken even while the last result still waits in the
// output register. Configuration is a plain write port
// (i_cfg_we/i_cfg_idx/i_cfg_data) and should be used only while idle.
module free_space_watermark_monitor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fswm_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fswm_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [fswm_pkg::MB_W-1:0] i_cfg_data
);
    import fswm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMPL,   // largest vs. active threshold, flag/reminder update
        S_CMPF,   // free vs. total for clamp
        S_MUL1,   // free*64 + free*32
        S_MUL2,   // + free*4, seed divide remainder
        S_DIV,    // 7 restoring divide steps
        S_DONE    // hand result to output register
    } t_state;

    // configuration
    logic [MB_W-1:0]   r_total_mb;
    logic [MB_W-1:0]   r_min_free_mb;
    logic [MB_W-1:0]   r_hwm_free_mb;
    logic [TICK_W-1:0] r_reminder_ticks;
    logic              r_solo_mode;

    // sequencer and datapath
    t_state            r_state, n_state;
    t_in_word          r_in, n_in;
    logic              r_space_short, n_space_short;
    logic [TICK_W-1:0] r_reminder_count, n_reminder_count;
    logic [UNIT_W-1:0] r_acc, n_acc;
    logic [MB_W-1:0]   r_rem, n_rem;
    logic [UTIL_W-1:0] r_low, n_low;     // dividend low bits in, quotient out
    logic [2:0]        r_cnt, n_cnt;
    logic              r_zero_total, n_zero_total;
    logic              r_free_ge, n_free_ge;
    logic              r_report, n_report;
    logic [1:0]        r_kind, n_kind;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    t_unit_op          w_op;
    t_unit_res         w_res;
    logic [MB_W-1:0]   w_limit;
    logic              w_now_short;
    logic [UTIL_W-1:0] w_util;

    fswm_addsub u_addsub (
        .i_op  (w_op),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_mb       <= '0;
            r_min_free_mb    <= '0;
            r_hwm_free_mb    <= '0;
            r_reminder_ticks <= 8'd12;
            r_solo_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOTAL_MB:       r_total_mb       <= i_cfg_data;
                REG_MIN_FREE_MB:    r_min_free_mb    <= i_cfg_data;
                REG_HWM_FREE_MB:    r_hwm_free_mb    <= i_cfg_data;
                REG_REMINDER_TICKS: r_reminder_ticks <= i_cfg_data[TICK_W-1:0];
                REG_SOLO_MODE:      r_solo_mode      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_limit     = r_space_short ? r_hwm_free_mb : r_min_free_mb;
    assign w_now_short = ~w_res.carry;   // largest < limit

    // operand select for the shared unit
    always_comb begin
        w_op.a   = '0;
        w_op.b   = '0;
        w_op.sub = 1'b1;
        case (r_state)
            S_CMPL: begin
                w_op.a = {8'b0, r_in.largest_free_mb};
                w_op.b = {8'b0, w_limit};
            end
            S_CMPF: begin
                w_op.a = {8'b0, r_in.free_mb};
                w_op.b = {8'b0, r_total_mb};
            end
            S_MUL1: begin
                w_op.a   = {2'b0, r_in.free_mb, 6'b0};
                w_op.b   = {3'b0, r_in.free_mb, 5'b0};
                w_op.sub = 1'b0;
            end
            S_MUL2: begin
                w_op.a   = r_acc;
                w_op.b   = {6'b0, r_in.free_mb, 2'b0};
                w_op.sub = 1'b0;
            end
            S_DIV: begin
                w_op.a = {7'b0, r_rem, r_low[UTIL_W-1]};
                w_op.b = {8'b0, r_total_mb};
            end
            default: ;
        endcase
    end

    // final utilization: quotient valid only when free < total and total != 0
    always_comb begin
        if (r_zero_total) begin
            w_util = UTIL_FULL;
        end else if (r_free_ge) begin
            w_util = '0;
        end else begin
            w_util = UTIL_FULL - r_low;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_in             = r_in;
        n_space_short    = r_space_short;
        n_reminder_count = r_reminder_count;
        n_acc            = r_acc;
        n_rem            = r_rem;
        n_low            = r_low;
        n_cnt            = r_cnt;
        n_zero_total     = r_zero_total;
        n_free_ge        = r_free_ge;
        n_report         = r_report;
        n_kind           = r_kind;
        n_out_valid      = r_out_valid;
        n_out_word       = r_out_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_state = S_CMPL;
                end
            end
            S_CMPL: begin
                n_report = 1'b0;
                n_kind   = MSG_NONE;
                if (w_now_short != r_space_short) begin
                    n_kind        = w_now_short ? MSG_ENTER : MSG_LEAVE;
                    n_report      = ~r_solo_mode;
                    n_space_short = w_now_short;
                end else if (r_space_short && (r_reminder_count == '0)) begin
                    n_kind = MSG_REMIND;
                end
                // counter runs every tick regardless of the flag
                n_reminder_count = (r_reminder_count == '0) ? r_reminder_ticks
                                                            : r_reminder_count - 1'b1;
                n_state = S_CMPF;
            end
            S_CMPF: begin
                n_free_ge    = w_res.carry;
                n_zero_total = (r_total_mb == '0);
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                n_acc   = w_res.sum;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // free < total => free*100 >> 7 < total, so 7 quotient bits suffice
                n_rem   = w_res.sum[UNIT_W-2:UTIL_W];
                n_low   = w_res.sum[UTIL_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_res.carry) begin
                    n_rem = w_res.sum[MB_W-1:0];
                end else begin
                    n_rem = {r_rem[MB_W-2:0], r_low[UTIL_W-1]};
                end
                n_low = {r_low[UTIL_W-2:0], w_res.carry};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'(UTIL_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_word.util_percent = w_util;
                    n_out_word.no_space     = r_space_short;
                    n_out_word.report_state = r_report;
                    n_out_word.message_kind = r_kind;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_space_short    <= 1'b0;
            r_reminder_count <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_space_short    <= n_space_short;
            r_reminder_count <= n_reminder_count;
            r_out_valid      <= n_out_valid;
        end
        r_in         <= n_in;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_low        <= n_low;
        r_cnt        <= n_cnt;
        r_zero_total <= n_zero_total;
        r_free_ge    <= n_free_ge;
        r_report     <= n_report;
        r_kind       <= n_kind;
        r_out_word   <= n_out_word;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_util_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.util_percent <= UTIL_FULL))
        else $error("utilization above 100");

    a_enter_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.message_kind == MSG_ENTER)) |-> o_out_word.no_space)
        else $error("enter message without no-space flag");

    a_leave_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.message_kind == MSG_LEAVE)) |-> !o_out_word.no_space)
        else $error("leave message with no-space flag set");

    a_report_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report_state) |->
            ((o_out_word.message_kind == MSG_ENTER) || (o_out_word.message_kind == MSG_LEAVE)))
        else $error("state report without flag change");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting a word");
`endif

endmodule
